>>> hdl/jss_pkg.sv
// shared types and constants for the jtag scan shifter
package jss_pkg;

  localparam int unsigned ChunkMax = 8;
  localparam int unsigned CountW   = 4;
  localparam int unsigned TimerW   = 16;

  localparam logic [1:0] OP_SCAN     = 2'd0;
  localparam logic [1:0] OP_SCAN_OUT = 2'd1;
  localparam logic [1:0] OP_SCAN_IN  = 2'd2;
  localparam logic [1:0] OP_RUN_CLK  = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic load;        // take a new chunk
    logic timer_load;  // restart half period count
    logic timer_dec;   // step the half period count down by one
    logic emit;        // finish one tck cycle, write the result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic count_zero;  // incoming chunk has no bits
    logic timer_zero;  // half period done
    logic last_bit;    // current tck cycle is the last of the chunk
    logic out_free;    // result register can take a beat
  } status_t;

endpackage

>>> hdl/jss_datapath.sv
// shift registers, pacing timer and result register of the jtag scan shifter
module jss_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [jss_pkg::TimerW-1:0]  cfg_data,
  input  logic [23:0]                 s_axis_tdata,
  input  logic                        s_axis_tlast,
  input  logic [2:0]                  s_axis_tuser,
  input  logic                        m_axis_tready,
  output logic                        m_axis_tvalid,
  output logic [15:0]                 m_axis_tdata,
  output logic                        m_axis_tlast,
  output logic                        m_axis_tuser,
  input  jss_pkg::cmd_t               cmd,
  output jss_pkg::status_t            status
);

  logic [jss_pkg::TimerW-1:0] half_period;
  logic [jss_pkg::TimerW-1:0] edge_timer;
  logic [7:0]                 tx_shift;
  logic [7:0]                 rx_shift;
  logic [7:0]                 tdo_shift;
  logic [jss_pkg::CountW-1:0] bits_remaining;
  logic [jss_pkg::CountW-1:0] chunk_len;
  logic                       captures;
  logic                       tms_on_last;

  logic [1:0]                 in_opcode;
  logic [7:0]                 in_tx;
  logic [jss_pkg::CountW-1:0] in_count;
  logic [jss_pkg::CountW-1:0] in_count_sat;
  logic [7:0]                 in_tdo;
  logic                       in_drives;
  logic [7:0]                 rx_next;
  logic [jss_pkg::CountW-1:0] align_full;
  logic [2:0]                 align;
  logic [7:0]                 rx_aligned;
  logic                       is_last;

  assign in_opcode = s_axis_tuser[1:0];
  assign in_tx     = s_axis_tdata[7:0];
  assign in_count  = s_axis_tdata[11:8];
  assign in_tdo    = s_axis_tdata[19:12];
  assign in_drives = (in_opcode == jss_pkg::OP_SCAN) || (in_opcode == jss_pkg::OP_SCAN_OUT);
  assign in_count_sat = (in_count > jss_pkg::CountW'(jss_pkg::ChunkMax))
                        ? jss_pkg::CountW'(jss_pkg::ChunkMax) : in_count;

  assign is_last    = (bits_remaining == jss_pkg::CountW'(1));
  assign rx_next    = {tdo_shift[0], rx_shift[7:1]};
  assign align_full = jss_pkg::CountW'(jss_pkg::ChunkMax) - chunk_len;
  assign align      = align_full[2:0];
  assign rx_aligned = rx_next >> align;

  assign status.count_zero = (in_count == '0);
  assign status.timer_zero = (edge_timer == '0);
  assign status.last_bit   = is_last;
  assign status.out_free   = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= '0;
    end else if (cfg_we) begin
      half_period <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_timer <= '0;
    end else if (cmd.timer_load) begin
      edge_timer <= half_period;
    end else if (cmd.timer_dec) begin
      edge_timer <= edge_timer - jss_pkg::TimerW'(1);
    end
  end

  // chunk state
  always_ff @(posedge clk) begin
    if (rst) begin
      bits_remaining <= '0;
    end else if (cmd.load) begin
      bits_remaining <= in_count_sat;
    end else if (cmd.emit) begin
      bits_remaining <= bits_remaining - jss_pkg::CountW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tx_shift    <= in_drives ? in_tx : 8'd0;
      rx_shift    <= '0;
      tdo_shift   <= in_tdo;
      chunk_len   <= in_count_sat;
      captures    <= (in_opcode == jss_pkg::OP_SCAN) || (in_opcode == jss_pkg::OP_SCAN_IN);
      tms_on_last <= s_axis_tlast && s_axis_tuser[2];
    end else if (cmd.emit) begin
      tx_shift  <= {1'b0, tx_shift[7:1]};
      rx_shift  <= rx_next;
      tdo_shift <= {1'b0, tdo_shift[7:1]};
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_axis_tdata <= {6'd0,
                       (is_last && captures) ? rx_aligned : 8'd0,
                       tms_on_last && is_last,
                       tx_shift[0]};
      m_axis_tlast <= is_last;
      m_axis_tuser <= is_last && captures;
    end
  end

endmodule

>>> hdl/jss_ctrl.sv
// sequencer for chunk intake, tck half periods and result beats
module jss_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  jss_pkg::status_t status,
  output jss_pkg::cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TCK_LOW,
    ST_TCK_HIGH,
    ST_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  assign s_axis_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (s_axis_tvalid && !status.count_zero) begin
          cmd.load       = 1'b1;
          cmd.timer_load = 1'b1;
          state_next     = ST_TCK_LOW;
        end
      end
      ST_TCK_LOW: begin
        if (status.timer_zero) begin
          cmd.timer_load = 1'b1;
          state_next     = ST_TCK_HIGH;
        end else begin
          cmd.timer_dec = 1'b1;
        end
      end
      ST_TCK_HIGH: begin
        if (status.timer_zero) begin
          state_next = ST_EMIT;
        end else begin
          cmd.timer_dec = 1'b1;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.last_bit) begin
            state_next = ST_IDLE;
          end else begin
            cmd.timer_load = 1'b1;
            state_next     = ST_TCK_LOW;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> hdl/jtag_scan_shifter.sv
// top level of the jtag scan shifter: controller and datapath
//
// usage: each slave beat is one chunk of 1..8 tck cycles. s_axis_tdata holds
// tx_byte, the tck count and tdo_bits, tlast marks the final chunk of a scan and
// tuser holds the opcode and the advance flag. for every tck cycle the block
// sends one master beat with the tdi and tms levels; the last beat of a chunk
// carries tlast, and for scan and scan-in also the captured tdo bits, right
// aligned, with tuser high. a chunk with zero bits is taken and dropped.
// timing: each tck cycle is a low half, a high half and a beat cycle; the
// half period counter sets the pace of both halves. one chunk is in work at
// a time; the next is taken once the previous chunk's last beat sits in the
// output register.
// stalls: while the receiver holds tready low the engine waits in its beat
// cycle, keeping the pending beat in the output register.
// reset: synchronous; clears the half period register (no pacing), the state
// machine and the output valid.
module jtag_scan_shifter (
  input  logic        clk,
  input  logic        rst,
  // configuration: half period in clock cycles
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  // chunk input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // tx_byte[7:0], tck_count[11:8], tdo_bits[19:12], zero[23:20]
  input  logic        s_axis_tlast,  // last_chunk
  input  logic [2:0]  s_axis_tuser,  // opcode[1:0], advance[2]
  // per tck cycle result
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // tdi_level[0], tms_level[1], rx_byte[9:2], zero[15:10]
  output logic        m_axis_tlast,  // last
  output logic        m_axis_tuser   // rx_valid
);

  jss_pkg::cmd_t    cmd;
  jss_pkg::status_t status;

  // state machine: intake, half period pacing, beat hand-off
  jss_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .status        (status),
    .cmd           (cmd)
  );

  // shift registers, timer, config register and output register
  jss_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tready (m_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cmd           (cmd),
    .status        (status)
  );

endmodule
